@@ src/tds_pkg.sv @@
// shared constants, types and fixed-point helpers of the tridiagonal solver
`default_nettype none
package tds_pkg;

   localparam int DATA_W    = 32;
   localparam int ROW_W     = 6;
   localparam int MAX_N_DEF = 64;
   localparam int FRAC_DEF  = 16;

   localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic                     ovf;
      logic signed [DATA_W-1:0] val;
   } sat_type;

   typedef struct packed {
      logic                     done;
      logic                     err;
      logic signed [DATA_W-1:0] quo;
   } div_res_type;

   // full product scaled down by the fraction bits (floor), then saturated
   function automatic sat_type qmul_sat(input logic signed [2*DATA_W-1:0] p,
                                        input int unsigned frac);
      logic signed [2*DATA_W-1:0] s;
      sat_type r;
      s = p >>> frac;
      r.ovf = (s[2*DATA_W-1:DATA_W-1] != {(DATA_W+1){1'b0}}) &&
              (s[2*DATA_W-1:DATA_W-1] != {(DATA_W+1){1'b1}});
      r.val = r.ovf ? (s[2*DATA_W-1] ? Q_MIN : Q_MAX) : s[DATA_W-1:0];
      return r;
   endfunction

   // saturating difference a - b
   function automatic sat_type sub_sat(input logic signed [DATA_W-1:0] a,
                                       input logic signed [DATA_W-1:0] b);
      logic [DATA_W:0] d;
      sat_type r;
      d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      r.ovf = d[DATA_W] != d[DATA_W-1];
      r.val = r.ovf ? (d[DATA_W] ? Q_MIN : Q_MAX) : d[DATA_W-1:0];
      return r;
   endfunction

endpackage
`default_nettype wire

@@ src/tds_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module tds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                            clock,
   input  wire logic                                            wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]                                wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]                                rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ src/tds_div.sv @@
// iterative restoring divider for q = (a << frac) / b, truncating, saturated
`default_nettype none
module tds_div #(
   parameter int FRAC_BITS = tds_pkg::FRAC_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic signed [tds_pkg::DATA_W-1:0]      dividend,
   input  wire logic signed [tds_pkg::DATA_W-1:0]      divisor,
   output tds_pkg::div_res_type                        res
);
   localparam int DW = tds_pkg::DATA_W;
   localparam int NW = DW + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic              run_ff, run_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [NW-1:0]     quo_ff, quo_in;
   logic [DW-1:0]     bm_ff, bm_in;
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;
   logic              aneg_ff, aneg_in;
   logic              anz_ff, anz_in;
   logic              perr_ff, perr_in;
   tds_pkg::div_res_type res_ff, res_in;

   logic [DW-1:0]     am;
   logic [DW:0]       trial;
   logic              ge;
   logic              big;

   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      bm_in   = bm_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      aneg_in = aneg_ff;
      anz_in  = anz_ff;
      perr_in = perr_ff;
      res_in  = res_ff;
      res_in.done = 1'b0;
      am    = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
      trial = {rem_ff, quo_ff[NW-1]};
      ge    = trial >= {1'b0, bm_ff};
      big   = 1'b0;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = {am, {FRAC_BITS{1'b0}}};
         bm_in   = divisor[DW-1] ? (~divisor + DW'(1)) : divisor;
         neg_in  = dividend[DW-1] ^ divisor[DW-1];
         zero_in = divisor == '0;
         aneg_in = dividend[DW-1];
         anz_in  = dividend != '0;
         perr_in = divisor[DW-1] | (divisor == '0);
      end else if (run_ff) begin
         if (cnt_ff == CW'(NW)) begin
            run_in      = 1'b0;
            res_in.done = 1'b1;
            if (zero_ff) begin
               res_in.err = perr_ff;
               res_in.quo = aneg_ff ? tds_pkg::Q_MIN :
                            (anz_ff ? tds_pkg::Q_MAX : '0);
            end else begin
               if (neg_ff) begin
                  big = (quo_ff[NW-1:DW] != '0) ||
                        (quo_ff[DW-1] && (quo_ff[DW-2:0] != '0));
               end else begin
                  big = quo_ff[NW-1:DW-1] != '0;
               end
               res_in.err = perr_ff | big;
               if (big) begin
                  res_in.quo = neg_ff ? tds_pkg::Q_MIN : tds_pkg::Q_MAX;
               end else begin
                  res_in.quo = neg_ff ? (~quo_ff[DW-1:0] + DW'(1)) : quo_ff[DW-1:0];
               end
            end
         end else begin
            rem_in = ge ? DW'(trial - {1'b0, bm_ff}) : trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], ge};
            cnt_in = cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         res_ff.done <= 1'b0;
      end else begin
         run_ff      <= run_in;
         res_ff.done <= res_in.done;
      end
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      bm_ff      <= bm_in;
      neg_ff     <= neg_in;
      zero_ff    <= zero_in;
      aneg_ff    <= aneg_in;
      anz_ff     <= anz_in;
      perr_ff    <= perr_in;
      res_ff.err <= res_in.err;
      res_ff.quo <= res_in.quo;
   end

   assign res = res_ff;
endmodule
`default_nettype wire

@@ src/tridiagonal_spd_solver.sv @@
// top level: row store, twisted elimination sequencer and solution output
//
// channel   direction  handshake            payload
// request   in         start & !busy        req_diag_value, req_offdiag_value,
//                                           req_rhs_value, req_row_last
// result    out        rsp_valid (1 cycle)  rsp_row_index, rsp_solution_value,
//                                           rsp_pivot_error, rsp_result_last
//
// a request that is not the last row is stored in the cycle it is taken, busy stays low
// the last row starts the solve: the elimination steps, substitutions and center divide
// are paced by the bit-serial divider and the one-read-port row memories
// a system of n rows yields n results once the solve is done
// reset clears the control state only; the row memories need no clearing
// the receiver cannot stall: results come one per cycle, busy high throughout
`default_nettype none
module tridiagonal_spd_solver #(
   parameter int MAX_N     = tds_pkg::MAX_N_DEF,
   parameter int FRAC_BITS = tds_pkg::FRAC_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic signed [tds_pkg::DATA_W-1:0]  req_diag_value,
   input  wire logic signed [tds_pkg::DATA_W-1:0]  req_offdiag_value,
   input  wire logic signed [tds_pkg::DATA_W-1:0]  req_rhs_value,
   input  wire logic                               req_row_last,
   output logic                                    rsp_valid,
   output logic [tds_pkg::ROW_W-1:0]               rsp_row_index,
   output logic signed [tds_pkg::DATA_W-1:0]       rsp_solution_value,
   output logic                                    rsp_pivot_error,
   output logic                                    rsp_result_last
);
   localparam int DW = tds_pkg::DATA_W;
   localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int CW = AW + 1;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PLAN  = 4'd1;
   localparam logic [3:0] S_R1    = 4'd2;
   localparam logic [3:0] S_R2    = 4'd3;
   localparam logic [3:0] S_R3    = 4'd4;
   localparam logic [3:0] S_X     = 4'd5;
   localparam logic [3:0] S_XS    = 4'd6;
   localparam logic [3:0] S_DW    = 4'd7;
   localparam logic [3:0] S_M1    = 4'd8;
   localparam logic [3:0] S_S1    = 4'd9;
   localparam logic [3:0] S_S2    = 4'd10;
   localparam logic [3:0] S_EMIT  = 4'd11;
   localparam logic [3:0] S_DRAIN = 4'd12;

   // solve phases
   localparam logic [2:0] PH_FA   = 3'd0;
   localparam logic [2:0] PH_FB   = 3'd1;
   localparam logic [2:0] PH_CEN  = 3'd2;
   localparam logic [2:0] PH_CD   = 3'd3;
   localparam logic [2:0] PH_CB   = 3'd4;
   localparam logic [2:0] PH_BCHK = 3'd5;
   localparam logic [2:0] PH_BB   = 3'd6;

   // row operation kinds
   localparam logic [1:0] K_ELIM = 2'd0;  // eliminate one row into its neighbor
   localparam logic [1:0] K_BACK = 2'd1;  // x[j] = (x[j] - e*x[nb]) / d[j]
   localparam logic [1:0] K_DIVO = 2'd2;  // x[j] = x[j] / d[j]

   typedef struct packed {
      logic [1:0]    kind;
      logic [AW-1:0] ea;   // offdiag address
      logic [AW-1:0] da1;  // first diag read (pivot)
      logic [AW-1:0] xa1;  // first rhs read
      logic [AW-1:0] wa;   // target row
   } op_type;

   logic [3:0]  st_ff, st_in;
   logic [2:0]  ph_ff, ph_in;
   logic [CW-1:0] rc_ff, rc_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] oc_ff, oc_in;
   logic        err_ff, err_in;
   op_type      op_ff, op_in;
   logic signed [DW-1:0] a_e_ff, a_e_in;
   logic signed [DW-1:0] a_ds_ff, a_ds_in;
   logic signed [DW-1:0] a_xs_ff, a_xs_in;
   logic signed [DW-1:0] a_dd_ff, a_dd_in;
   logic signed [DW-1:0] a_xd_ff, a_xd_in;
   logic signed [DW-1:0] t_ff, t_in;
   logic signed [2*DW-1:0] prod_ff, prod_in;
   logic        em_v_ff, em_v_in;
   logic        em_last_ff, em_last_in;
   logic [AW-1:0] em_idx_ff, em_idx_in;

   logic        acc;
   logic        last_row;
   logic [AW-1:0] idx;
   logic signed [DW-1:0] mul_a, mul_b, minu;
   tds_pkg::sat_type qm, sr;
   logic        ovf_any;
   logic        div_start;
   logic signed [DW-1:0] div_a;
   tds_pkg::div_res_type div_res;

   logic        d_we, x_we;
   logic [AW-1:0] d_wa, x_wa, e_ra, d_ra, x_ra;
   logic [DW-1:0] d_wd, x_wd, e_q, d_q, x_q;

   assign busy     = st_ff != S_IDLE;
   assign acc      = start & ~busy;
   assign idx      = rc_ff[AW-1:0];
   assign last_row = req_row_last | ((rc_ff + CW'(1)) >= CW'(MAX_N));

   // shared multiplier operands and saturating product-subtract
   assign mul_a   = (st_ff == S_X) ? a_e_ff : t_ff;
   assign mul_b   = (st_ff == S_M1) ? a_e_ff : a_xs_ff;
   assign minu    = (st_ff == S_S1) ? a_dd_ff : a_xd_ff;
   assign qm      = tds_pkg::qmul_sat(prod_ff, FRAC_BITS);
   assign sr      = tds_pkg::sub_sat(minu, qm.val);
   assign ovf_any = qm.ovf | sr.ovf;

   always_comb begin
      st_in   = st_ff;
      ph_in   = ph_ff;
      rc_in   = rc_ff;
      n_in    = n_ff;
      mid_in  = mid_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      oc_in   = oc_ff;
      err_in  = err_ff;
      op_in   = op_ff;
      a_e_in  = a_e_ff;
      a_ds_in = a_ds_ff;
      a_xs_in = a_xs_ff;
      a_dd_in = a_dd_ff;
      a_xd_in = a_xd_ff;
      t_in    = t_ff;
      prod_in = prod_ff;
      em_v_in    = 1'b0;
      em_last_in = em_last_ff;
      em_idx_in  = em_idx_ff;
      div_start  = 1'b0;
      div_a      = a_e_ff;
      case (st_ff)
         S_IDLE: begin
            if (acc) begin
               if (last_row) begin
                  n_in   = rc_ff + CW'(1);
                  rc_in  = '0;
                  mid_in = rc_ff >> 1;
                  lo_in  = '0;
                  hi_in  = rc_ff - CW'(1);
                  ph_in  = ((rc_ff >> 1) == '0) ? PH_CEN : PH_FA;
                  err_in = 1'b0;
                  st_in  = S_PLAN;
               end else begin
                  rc_in = rc_ff + CW'(1);
               end
            end
         end
         S_PLAN: begin
            st_in = S_R1;
            case (ph_ff)
               PH_FA: begin
                  // top end: row lo into row lo+1
                  op_in = '{K_ELIM, lo_ff[AW-1:0], lo_ff[AW-1:0], lo_ff[AW-1:0],
                            AW'(lo_ff + CW'(1))};
                  ph_in = PH_FB;
               end
               PH_FB: begin
                  // bottom end: row hi+1 into row hi
                  op_in = '{K_ELIM, hi_ff[AW-1:0], AW'(hi_ff + CW'(1)),
                            AW'(hi_ff + CW'(1)), hi_ff[AW-1:0]};
                  lo_in = lo_ff + CW'(1);
                  hi_in = hi_ff - CW'(1);
                  ph_in = ((lo_ff + CW'(1)) == mid_ff) ? PH_CEN : PH_FA;
               end
               PH_CEN: begin
                  if (n_ff[0]) begin
                     op_in = '{K_DIVO, mid_ff[AW-1:0], mid_ff[AW-1:0],
                               mid_ff[AW-1:0], mid_ff[AW-1:0]};
                     lo_in = mid_ff - CW'(1);
                     hi_in = mid_ff + CW'(1);
                     ph_in = PH_BCHK;
                  end else begin
                     op_in = '{K_ELIM, mid_ff[AW-1:0], mid_ff[AW-1:0],
                               mid_ff[AW-1:0], AW'(mid_ff + CW'(1))};
                     ph_in = PH_CD;
                  end
               end
               PH_CD: begin
                  op_in = '{K_DIVO, AW'(mid_ff + CW'(1)), AW'(mid_ff + CW'(1)),
                            AW'(mid_ff + CW'(1)), AW'(mid_ff + CW'(1))};
                  ph_in = PH_CB;
               end
               PH_CB: begin
                  op_in = '{K_BACK, mid_ff[AW-1:0], mid_ff[AW-1:0],
                            AW'(mid_ff + CW'(1)), mid_ff[AW-1:0]};
                  lo_in = mid_ff - CW'(1);
                  hi_in = mid_ff + CW'(2);
                  ph_in = PH_BCHK;
               end
               PH_BCHK: begin
                  if (hi_ff >= n_ff) begin
                     // substitution done, stream out the solution
                     st_in = S_EMIT;
                     oc_in = '0;
                  end else begin
                     op_in = '{K_BACK, lo_ff[AW-1:0], lo_ff[AW-1:0],
                               AW'(lo_ff + CW'(1)), lo_ff[AW-1:0]};
                     ph_in = PH_BB;
                  end
               end
               default: begin
                  op_in = '{K_BACK, AW'(hi_ff - CW'(1)), hi_ff[AW-1:0],
                            AW'(hi_ff - CW'(1)), hi_ff[AW-1:0]};
                  lo_in = lo_ff - CW'(1);
                  hi_in = hi_ff + CW'(1);
                  ph_in = PH_BCHK;
               end
            endcase
         end
         S_R1: st_in = S_R2;
         S_R2: begin
            a_e_in  = e_q;
            a_ds_in = d_q;
            a_xs_in = x_q;
            st_in   = S_R3;
         end
         S_R3: begin
            a_dd_in = d_q;
            a_xd_in = x_q;
            st_in   = S_X;
         end
         S_X: begin
            case (op_ff.kind)
               K_ELIM: begin
                  div_start = 1'b1;
                  div_a     = a_e_ff;
                  st_in     = S_DW;
               end
               K_BACK: begin
                  prod_in = mul_a * mul_b;
                  st_in   = S_XS;
               end
               default: begin
                  div_start = 1'b1;
                  div_a     = a_xs_ff;
                  st_in     = S_DW;
               end
            endcase
         end
         S_XS: begin
            div_start = 1'b1;
            div_a     = sr.val;
            err_in    = err_ff | ovf_any;
            st_in     = S_DW;
         end
         S_DW: begin
            if (div_res.done) begin
               err_in = err_ff | div_res.err;
               if (op_ff.kind == K_ELIM) begin
                  t_in  = div_res.quo;
                  st_in = S_M1;
               end else begin
                  st_in = S_PLAN;
               end
            end
         end
         S_M1: begin
            prod_in = mul_a * mul_b;
            st_in   = S_S1;
         end
         S_S1: begin
            prod_in = mul_a * mul_b;
            err_in  = err_ff | ovf_any;
            st_in   = S_S2;
         end
         S_S2: begin
            err_in = err_ff | ovf_any;
            st_in  = S_PLAN;
         end
         S_EMIT: begin
            em_v_in    = 1'b1;
            em_idx_in  = oc_ff[AW-1:0];
            em_last_in = (oc_ff + CW'(1)) == n_ff;
            if ((oc_ff + CW'(1)) == n_ff) begin
               st_in = S_DRAIN;
            end else begin
               oc_in = oc_ff + CW'(1);
            end
         end
         S_DRAIN: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         rc_ff   <= '0;
         err_ff  <= 1'b0;
         em_v_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         rc_ff   <= rc_in;
         err_ff  <= err_in;
         em_v_ff <= em_v_in;
      end
      ph_ff      <= ph_in;
      n_ff       <= n_in;
      mid_ff     <= mid_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      oc_ff      <= oc_in;
      op_ff      <= op_in;
      a_e_ff     <= a_e_in;
      a_ds_ff    <= a_ds_in;
      a_xs_ff    <= a_xs_in;
      a_dd_ff    <= a_dd_in;
      a_xd_ff    <= a_xd_in;
      t_ff       <= t_in;
      prod_ff    <= prod_in;
      em_last_ff <= em_last_in;
      em_idx_ff  <= em_idx_in;
   end

   // memory ports: requests write all three memories, the solve writes diag and rhs
   assign d_we = acc | (st_ff == S_S1);
   assign d_wa = acc ? idx : op_ff.wa;
   assign d_wd = acc ? req_diag_value : sr.val;
   assign x_we = acc | (st_ff == S_S2) |
                 ((st_ff == S_DW) && div_res.done && (op_ff.kind != K_ELIM));
   assign x_wa = acc ? idx : op_ff.wa;
   assign x_wd = acc ? req_rhs_value : ((st_ff == S_S2) ? sr.val : div_res.quo);
   assign e_ra = op_ff.ea;
   assign d_ra = (st_ff == S_R1) ? op_ff.da1 : op_ff.wa;
   assign x_ra = (st_ff == S_R1) ? op_ff.xa1 :
                 ((st_ff == S_EMIT) ? oc_ff[AW-1:0] : op_ff.wa);

   tds_ram #(.WIDTH(DW), .DEPTH(MAX_N)) u_diag (
      .clock(clock), .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
      .rd_addr(d_ra), .rd_data(d_q)
   );

   tds_ram #(.WIDTH(DW), .DEPTH(MAX_N)) u_offdiag (
      .clock(clock), .wr_en(acc), .wr_addr(idx), .wr_data(req_offdiag_value),
      .rd_addr(e_ra), .rd_data(e_q)
   );

   tds_ram #(.WIDTH(DW), .DEPTH(MAX_N)) u_rhs (
      .clock(clock), .wr_en(x_we), .wr_addr(x_wa), .wr_data(x_wd),
      .rd_addr(x_ra), .rd_data(x_q)
   );

   // one divider shared by every pivot division
   tds_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(a_ds_ff), .res(div_res)
   );

   assign rsp_valid          = em_v_ff;
   assign rsp_row_index      = tds_pkg::ROW_W'(em_idx_ff);
   assign rsp_solution_value = x_q;
   assign rsp_pivot_error    = err_ff;
   assign rsp_result_last    = em_last_ff;

   // results only while the solve is still marked busy
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside busy window");

   // divider completes only while the sequencer waits on it
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (st_ff == S_DW)) else $error("stray divider result");

   // a last row always launches a solve
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_row_last) |=> busy) else $error("solve not started");

   // the final result closes the burst
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_last) |=> !rsp_valid) else $error("result after last");

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// self-checking bench of the tridiagonal solver: row systems, predicted solutions, idling phases
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

   localparam int DATA_W   = tds_pkg::DATA_W;
   localparam int ROW_W    = tds_pkg::ROW_W;
   localparam int FRAC     = tds_pkg::FRAC_DEF;
   localparam int NMAX     = tds_pkg::MAX_N_DEF;
   localparam int WD_LIMIT = 40000; // exceeds the longest solve, of 64 rows

   typedef struct packed {
      logic [ROW_W-1:0]         row;
      logic signed [DATA_W-1:0] x;
      logic                     err;
      logic                     last;
   } solution_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [DATA_W-1:0] req_diag_value = '0;
   logic signed [DATA_W-1:0] req_offdiag_value = '0;
   logic signed [DATA_W-1:0] req_rhs_value = '0;
   logic req_row_last = 1'b0;
   logic rsp_valid;
   logic [ROW_W-1:0] rsp_row_index;
   logic signed [DATA_W-1:0] rsp_solution_value;
   logic rsp_pivot_error;
   logic rsp_result_last;

   tridiagonal_spd_solver i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_diag_value(req_diag_value), .req_offdiag_value(req_offdiag_value),
      .req_rhs_value(req_rhs_value), .req_row_last(req_row_last),
      .rsp_valid(rsp_valid), .rsp_row_index(rsp_row_index),
      .rsp_solution_value(rsp_solution_value), .rsp_pivot_error(rsp_pivot_error),
      .rsp_result_last(rsp_result_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // predictor state: rows of the system being loaded
   int         sys_rows;
   logic signed [DATA_W-1:0] d_rows [NMAX];
   logic signed [DATA_W-1:0] e_rows [NMAX];
   logic signed [DATA_W-1:0] b_rows [NMAX];
   bit         solve_err;
   solution_type pending_solutions [$];
   int         fail_count = 0;
   int         idle_pct = 0;
   int         quiet_cycles = 0;

   // ---------------- fixed-point predictor ----------------
   function automatic logic signed [DATA_W-1:0] clamp(input longint v);
      if (v > 64'sd2147483647) begin solve_err = 1; return 32'sh7fffffff; end
      if (v < -64'sd2147483648) begin solve_err = 1; return 32'sh80000000; end
      return v[DATA_W-1:0];
   endfunction

   // product floored by the fraction bits
   function automatic logic signed [DATA_W-1:0] fx_mul(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return clamp(p >>> FRAC);
   endfunction

   // quotient truncated toward zero, divisor is a pivot
   function automatic logic signed [DATA_W-1:0] fx_div(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
      longint num;
      if (b <= 0) solve_err = 1;
      if (b == 0) return a > 0 ? 32'sh7fffffff : (a < 0 ? 32'sh80000000 : 32'sh0);
      num = longint'(a) * (64'sd1 <<< FRAC);
      return clamp(num / longint'(b));
   endfunction

   function automatic logic signed [DATA_W-1:0] fx_sub(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
      return clamp(longint'(a) - longint'(b));
   endfunction

   // twisted elimination from both ends, then substitution outward
   task automatic predict_solution(input int n);
      logic signed [DATA_W-1:0] d [NMAX];
      logic signed [DATA_W-1:0] x [NMAX];
      logic signed [DATA_W-1:0] t;
      int mid, inx, kp1;
      solution_type s;
      d = d_rows;
      x = b_rows;
      solve_err = 0;
      if (n == 1) begin
         x[0] = fx_div(x[0], d[0]);
      end else begin
         mid = (n - 1) / 2;
         inx = n - 2;
         for (int k = 0; k < mid; k++) begin
            t = fx_div(e_rows[k], d[k]);
            d[k+1] = fx_sub(d[k+1], fx_mul(t, e_rows[k]));
            x[k+1] = fx_sub(x[k+1], fx_mul(t, x[k]));
            t = fx_div(e_rows[inx], d[inx+1]);
            d[inx] = fx_sub(d[inx], fx_mul(t, e_rows[inx]));
            x[inx] = fx_sub(x[inx], fx_mul(t, x[inx+1]));
            inx--;
         end
         inx = mid - 1;
         if ((n & 1) == 0) begin
            // 2x2 clean-up at the center
            t = fx_div(e_rows[mid], d[mid]);
            d[mid+1] = fx_sub(d[mid+1], fx_mul(t, e_rows[mid]));
            x[mid+1] = fx_sub(x[mid+1], fx_mul(t, x[mid]));
            x[mid+1] = fx_div(x[mid+1], d[mid+1]);
            x[mid] = fx_div(fx_sub(x[mid], fx_mul(e_rows[mid], x[mid+1])), d[mid]);
            mid++;
         end else begin
            x[mid] = fx_div(x[mid], d[mid]);
         end
         for (kp1 = mid + 1; kp1 < n; kp1++) begin
            x[inx] = fx_div(fx_sub(x[inx], fx_mul(e_rows[inx], x[inx+1])), d[inx]);
            x[kp1] = fx_div(fx_sub(x[kp1], fx_mul(e_rows[kp1-1], x[kp1-1])), d[kp1]);
            inx--;
         end
      end
      for (int i = 0; i < n; i++) begin
         s.row = i[ROW_W-1:0];
         s.x = x[i];
         s.err = solve_err;
         s.last = (i == n - 1);
         pending_solutions.push_back(s);
      end
   endtask

   // ---------------- request driver ----------------
   task automatic send_row(input logic signed [DATA_W-1:0] dv,
                           input logic signed [DATA_W-1:0] ev,
                           input logic signed [DATA_W-1:0] bv,
                           input logic lst);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_diag_value <= dv;
      req_offdiag_value <= ev;
      req_rhs_value <= bv;
      req_row_last <= lst;
      @(posedge clock);
      while (busy) @(posedge clock);
      // request taken at this edge
      d_rows[sys_rows] = dv;
      e_rows[sys_rows] = ev;
      b_rows[sys_rows] = bv;
      if (lst || sys_rows + 1 >= NMAX) begin
         predict_solution(sys_rows + 1);
         sys_rows = 0;
      end else begin
         sys_rows++;
      end
   endtask

   // a well-conditioned system: dominant diagonal, small couplings
   task automatic send_system(input int n);
      for (int i = 0; i < n; i++)
         send_row(32'sd131072 + $urandom_range(32'h3ffff),
                  $signed($urandom_range(32'h7fff)) - 32'sd16384,
                  $signed($urandom()) >>> $urandom_range(31),
                  i == n - 1);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_solutions.size() != 0) @(posedge clock);
   endtask

   // ---------------- tests ----------------
   task automatic test_directed();
      send_row(32'sd65536, 32'sd0, 32'sd65536, 1'b1);      // single divide
      send_row(32'sd0, 32'sd0, 32'sd5, 1'b1);              // zero pivot, positive
      send_row(32'sd0, 32'sd0, -32'sd5, 1'b1);             // zero pivot, negative
      send_row(32'sd0, 32'sd0, 32'sd0, 1'b1);              // zero pivot, zero
      send_row(-32'sd65536, 32'sd0, 32'sd65536, 1'b1);     // negative pivot
      send_row(32'sd1, 32'sh7fffffff, 32'sh7fffffff, 1'b1); // saturating quotient
      send_row(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1'b0); // extremes
      send_row(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b1);
      send_system(2);
      send_system(3);
      send_system(4);
      send_system(5);
   endtask

   task automatic test_max_rows();
      // row_last never set: the 64th row closes the system
      for (int i = 0; i < NMAX; i++)
         send_row(32'sd196608, 32'sd4096, $signed($urandom()) >>> 8, 1'b0);
   endtask

   task automatic test_random(input int pct, input int rows);
      int sent;
      sent = 0;
      idle_pct = pct;
      while (sent < rows) begin
         int n;
         n = $urandom_range(7, 1);
         if ($urandom_range(9) == 0) begin
            // noise: arbitrary values on every bit
            for (int i = 0; i < n; i++)
               send_row($urandom(), $urandom(), $urandom(), i == n - 1);
         end else begin
            send_system(n);
         end
         sent += n;
      end
   endtask

   task automatic test_pause_drain();
      send_system(3);
      wait_drained(); // sender holds off until every result is in
      send_system(2);
   endtask

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         solution_type exp_s;
         if (pending_solutions.size() == 0) begin
            $error("unexpected result row %0d", rsp_row_index);
            fail_count++;
         end else begin
            exp_s = pending_solutions.pop_front();
            if (rsp_row_index !== exp_s.row) begin
               $error("row_index exp %0d got %0d", exp_s.row, rsp_row_index);
               fail_count++;
            end
            if (rsp_solution_value !== exp_s.x) begin
               $error("solution_value exp %0d got %0d", exp_s.x, rsp_solution_value);
               fail_count++;
            end
            if (rsp_pivot_error !== exp_s.err) begin
               $error("pivot_error exp %0d got %0d", exp_s.err, rsp_pivot_error);
               fail_count++;
            end
            if (rsp_result_last !== exp_s.last) begin
               $error("result_last exp %0d got %0d", exp_s.last, rsp_result_last);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no request and no result accepted
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("tridiagonal_spd_solver test failed");
         $finish;
      end
   end

   initial begin
      sys_rows = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_max_rows();
      test_random(0, 70);
      test_pause_drain();
      test_random(63, 70);
      test_random(34, 70);
      test_random(0, 60);
      wait_drained();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_solutions.size() == 0)
         $display("tridiagonal_spd_solver test passed");
      else
         $display("tridiagonal_spd_solver test failed");
      $finish;
   end

endmodule
`default_nettype wire
